// ===== sv/solt_pkg.sv =====
// Shared types and constants for the self-organizing list table.
// Depends on nothing; every module of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package solt_pkg;

   localparam int DEPTH  = 256;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int WORD_W = 32;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CNT_W-1:0]  cnt_type;

   typedef enum logic [1:0] {
      OP_APPEND    = 2'd0,
      OP_GET       = 2'd1,
      OP_SEARCH    = 2'd2,
      OP_TRANSPOSE = 2'd3
   } opcode_type;

   typedef struct packed {
      opcode_type         opcode;
      logic signed [31:0] value;
      logic [7:0]         index;
   } req_word_type;

   typedef struct packed {
      logic               found;
      logic [7:0]         position;
      logic signed [31:0] word_out;
      logic               full_res;
   } rsp_word_type;

   typedef enum logic [2:0] {
      RES_APPEND,
      RES_FULL,
      RES_MISS,
      RES_GET,
      RES_HIT,
      RES_HIT_SWAP
   } res_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_GET_WAIT,
      ST_SCAN,
      ST_SWAP_LO,
      ST_SWAP_HI,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic        latch_req;
      logic        append_wr;
      logic        get_rd;
      logic        scan_start;
      logic        scan_step;
      logic        swap_lo_wr;
      logic        swap_hi_wr;
      logic        res_load;
      res_sel_type res_sel;
      logic        rsp_load;
   } solt_cmd_type;

   typedef struct packed {
      opcode_type opcode;
      logic       room;
      logic       get_ok;
      logic       hit;
      logic       scan_done;
      logic       hit_head;
   } solt_status_type;

endpackage

`default_nettype wire

// ===== sv/solt_datapath.sv =====
// Datapath: entry memory, count, scan pointers, result staging and output word.
// Depends on solt_pkg; driven by solt_ctrl through the command struct.
`timescale 1ns / 1ps
`default_nettype none

module solt_datapath
   import solt_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire req_word_type    req_data,
   input  wire solt_cmd_type    cmd,
   output solt_status_type      status,
   output rsp_word_type         rsp_data
);

   logic [WORD_W-1:0] mem_ff [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   req_word_type      req_ff;
   cnt_type           count_ff,     count_in;
   cnt_type           issue_ptr_ff, issue_ptr_in;
   logic              pend_valid_ff, pend_valid_in;
   addr_type          pend_addr_ff, pend_addr_in;
   logic [WORD_W-1:0] prev_word_ff, prev_word_in;
   rsp_word_type      res_ff,       res_in;
   rsp_word_type      rsp_ff;

   logic              wr_en;
   addr_type          wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic              rd_en;
   addr_type          rd_addr;
   logic              issue_more;
   addr_type          hit_prev;

   assign issue_more = issue_ptr_ff < count_ff;
   assign hit_prev   = pend_addr_ff - addr_type'(1);

   always_comb begin
      status.opcode    = req_ff.opcode;
      status.room      = count_ff < cnt_type'(DEPTH);
      status.get_ok    = int'(req_ff.index) < int'(count_ff);
      status.hit       = pend_valid_ff && (rd_data_ff == $unsigned(req_ff.value));
      status.scan_done = !pend_valid_ff && !issue_more;
      status.hit_head  = pend_addr_ff == '0;
   end

   // single write port, single registered read port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = count_ff[ADDR_W-1:0];
      wr_data = $unsigned(req_ff.value);
      if (cmd.append_wr) begin
         wr_en = 1'b1;
      end else if (cmd.swap_lo_wr) begin
         wr_en   = 1'b1;
         wr_addr = hit_prev;
      end else if (cmd.swap_hi_wr) begin
         wr_en   = 1'b1;
         wr_addr = pend_addr_ff;
         wr_data = prev_word_ff;
      end
      rd_en   = cmd.get_rd || (cmd.scan_step && issue_more);
      rd_addr = cmd.get_rd ? addr_type'(req_ff.index) : issue_ptr_ff[ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   always_comb begin
      count_in      = count_ff;
      issue_ptr_in  = issue_ptr_ff;
      pend_valid_in = pend_valid_ff;
      pend_addr_in  = pend_addr_ff;
      prev_word_in  = prev_word_ff;
      if (cmd.append_wr) begin
         count_in = count_ff + cnt_type'(1);
      end
      if (cmd.scan_start) begin
         issue_ptr_in  = '0;
         pend_valid_in = 1'b0;
      end else if (cmd.scan_step) begin
         // a pending compare that reaches here missed: keep it as the predecessor
         if (pend_valid_ff) begin
            prev_word_in = rd_data_ff;
         end
         if (issue_more) begin
            issue_ptr_in  = issue_ptr_ff + cnt_type'(1);
            pend_valid_in = 1'b1;
            pend_addr_in  = issue_ptr_ff[ADDR_W-1:0];
         end else begin
            pend_valid_in = 1'b0;
         end
      end
   end

   always_comb begin
      res_in = '0;
      case (cmd.res_sel)
         RES_APPEND: begin
            res_in.found    = 1'b1;
            res_in.position = 8'(count_ff);
         end
         RES_FULL: begin
            res_in.full_res = 1'b1;
         end
         RES_MISS: begin
            res_in = '0;
         end
         RES_GET: begin
            res_in.found    = 1'b1;
            res_in.position = req_ff.index;
            res_in.word_out = $signed(rd_data_ff);
         end
         RES_HIT: begin
            res_in.found    = 1'b1;
            res_in.position = 8'(pend_addr_ff);
         end
         RES_HIT_SWAP: begin
            res_in.found    = 1'b1;
            res_in.position = 8'(hit_prev);
         end
         default: begin
            res_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_ptr_ff <= issue_ptr_in;
      pend_addr_ff <= pend_addr_in;
      prev_word_ff <= prev_word_in;
      if (cmd.latch_req) begin
         req_ff <= req_data;
      end
      if (cmd.res_load) begin
         res_ff <= res_in;
      end
      if (cmd.rsp_load) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

// ===== sv/solt_ctrl.sv =====
// Controller: sequences each operation and owns both handshakes.
// Depends on solt_pkg; drives solt_datapath through the command struct.
`timescale 1ns / 1ps
`default_nettype none

module solt_ctrl
   import solt_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   input  wire solt_status_type status,
   output solt_cmd_type         cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.res_sel = RES_MISS;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (status.opcode)
               OP_APPEND: begin
                  cmd.res_load = 1'b1;
                  if (status.room) begin
                     cmd.append_wr = 1'b1;
                     cmd.res_sel   = RES_APPEND;
                  end else begin
                     cmd.res_sel = RES_FULL;
                  end
                  state_in = ST_FINISH;
               end
               OP_GET: begin
                  if (status.get_ok) begin
                     cmd.get_rd = 1'b1;
                     state_in   = ST_GET_WAIT;
                  end else begin
                     cmd.res_load = 1'b1;
                     state_in     = ST_FINISH;
                  end
               end
               default: begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_SCAN;
               end
            endcase
         end
         ST_GET_WAIT: begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_GET;
            state_in     = ST_FINISH;
         end
         ST_SCAN: begin
            if (status.hit) begin
               if (status.opcode == OP_TRANSPOSE && !status.hit_head) begin
                  state_in = ST_SWAP_LO;
               end else begin
                  cmd.res_load = 1'b1;
                  cmd.res_sel  = RES_HIT;
                  state_in     = ST_FINISH;
               end
            end else if (status.scan_done) begin
               cmd.res_load = 1'b1;
               state_in     = ST_FINISH;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_SWAP_LO: begin
            cmd.swap_lo_wr = 1'b1;
            cmd.res_load   = 1'b1;
            cmd.res_sel    = RES_HIT_SWAP;
            state_in       = ST_SWAP_HI;
         end
         ST_SWAP_HI: begin
            cmd.swap_hi_wr = 1'b1;
            state_in       = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

endmodule

`default_nettype wire

// ===== sv/self_organizing_list_table.sv =====
// Top level of the self-organizing list table: controller plus datapath.
// Depends on solt_pkg, solt_ctrl and solt_datapath.
//
// One word in, one word out per operation, one operation at a time. A search
// reads the stored entries in order and stops at the first match; one that
// misses reads all N stored entries. The scan reads one entry per cycle
// through the single read port of the entry memory. A transpose that moves
// its match then makes the two write-backs of the swap. A new word is
// accepted while the previous result waits on the output register. No
// clearing pass runs after reset: only slots below the count are ever read.
`timescale 1ns / 1ps
`default_nettype none

module self_organizing_list_table
   import solt_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_data
);

   solt_cmd_type    cmd;
   solt_status_type status;

   solt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   solt_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

// ===== sv/solt_checker.sv =====
// Port-level checks on the self-organizing list table result channel.
// Depends on solt_pkg; bound to self_organizing_list_table below.
`timescale 1ns / 1ps
`default_nettype none

module solt_checker
   import solt_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_stall,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire rsp_word_type rsp_data
);

   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word accepted while an operation runs");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed or dropped");

   a_miss_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.position == 8'd0)
      else $error("position nonzero on a miss");

   a_word_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.word_out != 32'sd0 |-> rsp_data.found)
      else $error("word returned without a hit");

   a_full_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.full_res |-> !rsp_data.found && rsp_data.word_out == 32'sd0)
      else $error("full flagged on a stored or returning word");

endmodule

bind self_organizing_list_table solt_checker u_solt_checker (.*);

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for self_organizing_list_table: directed and random words,
// predicted by a transpose-list mirror and checked field by field.
// Depends on solt_pkg and the self_organizing_list_table RTL.
`timescale 1ns / 1ps

module tb_top;
   import solt_pkg::*;

   localparam int IDLE_LIMIT  = 4000;
   localparam int TAIL_CYCLES = DEPTH + 16;

   class list_mirror;
      logic [31:0]  slots [DEPTH];
      cnt_type      used;
      rsp_word_type pending_answers [$];
      int           mismatches;

      function new();
         used = '0;
         mismatches = 0;
      endfunction

      function int size();
         return int'(used);
      endfunction

      function logic [31:0] word_at(int i);
         return slots[addr_type'(i)];
      endfunction

      function int outstanding();
         return pending_answers.size();
      endfunction

      function void take_request(req_word_type rq);
         rsp_word_type ans;
         int           hit;
         int           i;
         logic [31:0]  tmp;
         ans = '0;
         hit = -1;
         case (rq.opcode)
            OP_APPEND: begin
               if (used < DEPTH) begin
                  slots[used[7:0]] = rq.value;
                  ans.found = 1'b1;
                  ans.position = used[7:0];
                  used = used + 1'b1;
               end else begin
                  ans.full_res = 1'b1;
               end
            end
            OP_GET: begin
               if (rq.index < used) begin
                  ans.found = 1'b1;
                  ans.position = rq.index;
                  ans.word_out = slots[rq.index];
               end
            end
            default: begin
               i = 0;
               while (hit < 0 && i < used) begin
                  if (slots[addr_type'(i)] == rq.value)
                     hit = i;
                  i++;
               end
               if (hit >= 0) begin
                  ans.found = 1'b1;
                  ans.position = hit[7:0];
                  if (rq.opcode == OP_TRANSPOSE && hit > 0) begin
                     tmp = slots[addr_type'(hit - 1)];
                     slots[addr_type'(hit - 1)] = slots[addr_type'(hit)];
                     slots[addr_type'(hit)] = tmp;
                     ans.position = hit[7:0] - 8'd1;
                  end
               end
            end
         endcase
         pending_answers.push_back(ans);
      endfunction

      function void check_answer(rsp_word_type got);
         rsp_word_type want;
         if (pending_answers.size() == 0) begin
            $error("unexpected result word %h", got);
            mismatches++;
            return;
         end
         want = pending_answers.pop_front();
         if (got.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, got.found);
            mismatches++;
         end
         if (got.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, got.position);
            mismatches++;
         end
         if (got.word_out !== want.word_out) begin
            $error("word_out: expected %h, got %h", want.word_out, got.word_out);
            mismatches++;
         end
         if (got.full_res !== want.full_res) begin
            $error("full_res: expected %0d, got %0d", want.full_res, got.full_res);
            mismatches++;
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_data;

   list_mirror mirror = new();
   bit         calm = 1'b0;
   int         stall_left = 0;
   int         idle_cycles = 0;

   self_organizing_list_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // result side back-pressure: runs of stall and ready, mostly short
   always @(negedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
      end else if ($urandom_range(0, 99) < 50) begin
         rsp_stall <= 1'b0;
         stall_left = $urandom_range(0, 6);
      end else begin
         rsp_stall <= 1'b1;
         stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 2);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         mirror.check_answer(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_word(input req_word_type rq);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      do
         @(posedge clock);
      while (req_stall !== 1'b0);
      mirror.take_request(rq);
   endtask

   task automatic send_op(input opcode_type op, input logic [31:0] v, input logic [7:0] ix);
      req_word_type rq;
      rq.opcode = op;
      rq.value  = v;
      rq.index  = ix;
      send_word(rq);
   endtask

   task automatic make_item(input int append_pct, output req_word_type rq);
      int r;
      int n;
      n = mirror.size();
      rq.value = $urandom;
      rq.index = 8'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (r < append_pct) begin
         rq.opcode = OP_APPEND;
         if ($urandom_range(0, 3) == 0)
            rq.value = $urandom_range(0, 7) - 4;
      end else begin
         r = $urandom_range(0, 2);
         rq.opcode = (r == 0) ? OP_GET : (r == 1) ? OP_SEARCH : OP_TRANSPOSE;
         if (rq.opcode == OP_GET) begin
            if (n > 0 && $urandom_range(0, 4) != 0)
               rq.index = 8'($urandom_range(0, n - 1));
         end else if (n > 0 && $urandom_range(0, 3) != 0) begin
            rq.value = mirror.word_at($urandom_range(0, n - 1));
         end
      end
   endtask

   initial begin
      req_word_type rq;
      int           k;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty store
      send_op(OP_GET, 32'h0, 8'd0);
      send_op(OP_SEARCH, 32'h0, 8'd0);
      send_op(OP_TRANSPOSE, 32'h0, 8'd255);
      // extremes and a duplicate
      send_op(OP_APPEND, 32'h8000_0000, 8'd0);
      send_op(OP_APPEND, 32'h7FFF_FFFF, 8'd255);
      send_op(OP_APPEND, 32'h0, 8'd0);
      send_op(OP_APPEND, 32'hFFFF_FFFF, 8'd0);
      send_op(OP_APPEND, 32'h7FFF_FFFF, 8'd0);
      send_op(OP_GET, 32'hFFFF_FFFF, 8'd0);
      send_op(OP_GET, 32'h0, 8'd4);
      send_op(OP_GET, 32'h0, 8'd5);
      send_op(OP_GET, 32'h0, 8'd255);
      send_op(OP_SEARCH, 32'h7FFF_FFFF, 8'd0);
      send_op(OP_SEARCH, 32'h1234_5678, 8'd0);
      // head match, mid swap, first of duplicates, miss
      send_op(OP_TRANSPOSE, 32'h8000_0000, 8'd0);
      send_op(OP_TRANSPOSE, 32'hFFFF_FFFF, 8'd0);
      send_op(OP_TRANSPOSE, 32'h7FFF_FFFF, 8'd0);
      send_op(OP_GET, 32'h0, 8'd1);
      send_op(OP_TRANSPOSE, 32'hDEAD_BEEF, 8'd0);
      send_op(OP_APPEND, 32'h5555_5555, 8'hAA);
      send_op(OP_APPEND, 32'hAAAA_AAAA, 8'h55);

      for (k = 0; k < 150; k++) begin
         calm = (k < 30);
         make_item(35, rq);
         send_word(rq);
      end
      calm = 1'b0;

      // fill to the top, then push past it
      while (mirror.size() < DEPTH) begin
         make_item(100, rq);
         send_word(rq);
      end
      for (k = 0; k < 6; k++) begin
         make_item(100, rq);
         send_word(rq);
      end

      for (k = 0; k < 90; k++) begin
         calm = (k >= 60 && k < 75);
         make_item(10, rq);
         send_word(rq);
      end
      calm = 1'b0;

      @(negedge clock);
      req_valid <= 1'b0;
      while (mirror.outstanding() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mirror.mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
